// ===== hw/rtl/bvh_pkg.sv =====
// ----------------------------------------------------------------------------
// bvh_pkg
// Shared types, protocol codes and fixed command frames for the bill
// validator host protocol unit.
// ----------------------------------------------------------------------------
package bvh_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CREDIT_W = 20;
   localparam int unsigned NUM_BILL = 6;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BILL_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BILL_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BILL_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BILL_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BILL_4 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BILL_5 = 3'd6;

   // request types
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   // result kinds
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_CREDIT = 1'b1;

   // received status codes
   localparam logic [BYTE_W-1:0] SYNC_BYTE        = 8'hFC;
   localparam logic [BYTE_W-1:0] LEN_OFFSET       = 8'h02;
   localparam logic [BYTE_W-1:0] ST_IDLING        = 8'h11;
   localparam logic [BYTE_W-1:0] ST_ESCROW        = 8'h13;
   localparam logic [BYTE_W-1:0] ST_VEND_VALID    = 8'h15;
   localparam logic [BYTE_W-1:0] ST_STACKED       = 8'h16;
   localparam logic [BYTE_W-1:0] ST_DISABLED      = 8'h1A;
   localparam logic [BYTE_W-1:0] ST_POWERUP       = 8'h40;
   localparam logic [BYTE_W-1:0] ST_POWERUP_ACC   = 8'h41;
   localparam logic [BYTE_W-1:0] ST_POWERUP_STACK = 8'h42;
   localparam logic [BYTE_W-1:0] BILL_CODE_FIRST  = 8'h61;
   localparam logic [BYTE_W-1:0] BILL_CODE_LAST   = 8'h68;

   // command frames
   localparam logic [2:0] FRM_STATUS  = 3'd0;
   localparam logic [2:0] FRM_ACK     = 3'd1;
   localparam logic [2:0] FRM_RESET   = 3'd2;
   localparam logic [2:0] FRM_STACK   = 3'd3;
   localparam logic [2:0] FRM_RETURN  = 3'd4;
   localparam logic [2:0] FRM_ENABLE  = 3'd5;
   localparam logic [2:0] FRM_DISABLE = 3'd6;

   typedef logic [NUM_BILL-1:0][CREDIT_W-1:0] bill_values_type;

   // one queued job: an optional credit report followed by a frame
   typedef struct packed {
      logic [2:0]          frame;
      logic                credit;
      logic [CREDIT_W-1:0] value;
   } job_type;

   function automatic logic [2:0] frame_last_idx(input logic [2:0] frame);
      logic [2:0] r;
      if (frame == FRM_ENABLE || frame == FRM_DISABLE) begin
         r = 3'd5;
      end else begin
         r = 3'd4;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] frame_byte(input logic [2:0] frame,
                                                    input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      b = '0;
      if (idx == 3'd0) begin
         b = SYNC_BYTE;
      end else if (idx == 3'd1) begin
         b = (frame == FRM_ENABLE || frame == FRM_DISABLE) ? 8'h06 : 8'h05;
      end else begin
         unique case (frame)
            FRM_STATUS: begin
               unique case (idx)
                  3'd2:    b = 8'h11;
                  3'd3:    b = 8'h27;
                  default: b = 8'h56;
               endcase
            end
            FRM_ACK: begin
               unique case (idx)
                  3'd2:    b = 8'h50;
                  3'd3:    b = 8'hAA;
                  default: b = 8'h05;
               endcase
            end
            FRM_RESET: begin
               unique case (idx)
                  3'd2:    b = 8'h40;
                  3'd3:    b = 8'h2B;
                  default: b = 8'h15;
               endcase
            end
            FRM_STACK: begin
               unique case (idx)
                  3'd2:    b = 8'h41;
                  3'd3:    b = 8'hA2;
                  default: b = 8'h04;
               endcase
            end
            FRM_RETURN: begin
               unique case (idx)
                  3'd2:    b = 8'h43;
                  3'd3:    b = 8'hB0;
                  default: b = 8'h27;
               endcase
            end
            FRM_ENABLE: begin
               unique case (idx)
                  3'd2:    b = 8'hC3;
                  3'd3:    b = 8'h00;
                  3'd4:    b = 8'h04;
                  default: b = 8'hD6;
               endcase
            end
            FRM_DISABLE: begin
               unique case (idx)
                  3'd2:    b = 8'hC3;
                  3'd3:    b = 8'h01;
                  3'd4:    b = 8'h8D;
                  default: b = 8'hC7;
               endcase
            end
            default: b = '0;
         endcase
      end
      return b;
   endfunction

endpackage

// ===== hw/rtl/bvh_front.sv =====
// ----------------------------------------------------------------------------
// bvh_front
// Deframes received bytes, tracks escrow state and turns each completed
// message or poll tick into one job for the transmit side.
// ----------------------------------------------------------------------------
module bvh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [bvh_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                      enable_acceptor,
   input  bvh_pkg::bill_values_type  bill_values,
   input  logic                      job_full,
   output logic                      job_push,
   output bvh_pkg::job_type          job_data
);
   import bvh_pkg::*;

   localparam logic [1:0] PH_SYNC = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [1:0]        pos_ff, pos_in;
   logic [BYTE_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] arg_ff, arg_in;
   logic              ticket_ff, ticket_in;
   logic [2:0]        bill_idx_ff, bill_idx_in;
   logic              bill_held_ff, bill_held_in;

   logic              accept;
   logic [BYTE_W-1:0] left_dec;
   logic [BYTE_W-1:0] cur_status;
   logic [BYTE_W-1:0] cur_arg;
   logic [BYTE_W-1:0] bill_off;
   logic [CREDIT_W-1:0] held_value;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign left_dec  = bytes_left_ff - 8'd1;
   assign cur_status = (pos_ff == 2'd0) ? req_rx_byte : status_ff;
   assign cur_arg    = (pos_ff == 2'd1) ? req_rx_byte : arg_ff;
   assign bill_off   = cur_arg - BILL_CODE_FIRST;

   always_comb begin
      held_value = '0;
      if (bill_held_ff) begin
         unique case (bill_idx_ff)
            3'd0:    held_value = bill_values[0];
            3'd1:    held_value = bill_values[1];
            3'd2:    held_value = bill_values[2];
            3'd3:    held_value = bill_values[3];
            3'd4:    held_value = bill_values[4];
            3'd5:    held_value = bill_values[5];
            default: held_value = '0;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      arg_in        = arg_ff;
      ticket_in     = ticket_ff;
      bill_idx_in   = bill_idx_ff;
      bill_held_in  = bill_held_ff;
      job_push      = 1'b0;
      job_data      = '{frame: FRM_STATUS, credit: 1'b0, value: '0};
      if (accept) begin
         if (req_type == REQ_POLL) begin
            job_push = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_SYNC: begin
                  if (req_rx_byte == SYNC_BYTE) begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  bytes_left_in = req_rx_byte - LEN_OFFSET;
                  pos_in        = 2'd0;
                  phase_in      = PH_BODY;
               end
               default: begin
                  if (pos_ff == 2'd0) begin
                     status_in = req_rx_byte;
                     pos_in    = 2'd1;
                  end else if (pos_ff == 2'd1) begin
                     arg_in = req_rx_byte;
                     pos_in = 2'd2;
                  end
                  bytes_left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_SYNC;
                     job_push = 1'b1;
                     // default frame is the status request
                     unique case (cur_status)
                        ST_IDLING: begin
                           if (!enable_acceptor) begin
                              job_data.frame = FRM_DISABLE;
                           end
                        end
                        ST_ESCROW: begin
                           if (cur_arg >= BILL_CODE_FIRST && cur_arg <= BILL_CODE_LAST) begin
                              bill_idx_in    = bill_off[2:0];
                              bill_held_in   = 1'b1;
                              ticket_in      = 1'b1;
                              job_data.frame = FRM_STACK;
                           end else begin
                              ticket_in      = 1'b0;
                              job_data.frame = FRM_RETURN;
                           end
                        end
                        ST_VEND_VALID: begin
                           if (ticket_ff) begin
                              job_data.frame = FRM_ACK;
                           end
                        end
                        ST_STACKED: begin
                           if (ticket_ff) begin
                              bill_held_in    = 1'b0;
                              bill_idx_in     = '0;
                              ticket_in       = 1'b0;
                              job_data.credit = (held_value != '0);
                              job_data.value  = held_value;
                           end
                        end
                        ST_DISABLED: begin
                           if (enable_acceptor) begin
                              job_data.frame = FRM_ENABLE;
                           end
                        end
                        ST_POWERUP, ST_POWERUP_ACC, ST_POWERUP_STACK: begin
                           job_data.frame = FRM_RESET;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC;
         bytes_left_ff <= '0;
         pos_ff        <= '0;
         status_ff     <= '0;
         arg_ff        <= '0;
         ticket_ff     <= 1'b0;
         bill_idx_ff   <= '0;
         bill_held_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         pos_ff        <= pos_in;
         status_ff     <= status_in;
         arg_ff        <= arg_in;
         ticket_ff     <= ticket_in;
         bill_idx_ff   <= bill_idx_in;
         bill_held_ff  <= bill_held_in;
      end
   end

endmodule

// ===== hw/rtl/bvh_queue.sv =====
// ----------------------------------------------------------------------------
// bvh_queue
// Small job queue between the receive front and the transmit back.
// ----------------------------------------------------------------------------
module bvh_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bvh_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output bvh_pkg::job_type pop_data
);
   import bvh_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/bvh_back.sv =====
// ----------------------------------------------------------------------------
// bvh_back
// Takes jobs from the queue and emits their results one beat at a time:
// the optional credit report, then the command frame bytes.
// ----------------------------------------------------------------------------
module bvh_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_empty,
   input  bvh_pkg::job_type            job_data,
   output logic                        job_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_result_kind,
   output logic [bvh_pkg::BYTE_W-1:0]   rsp_tx_byte,
   output logic [bvh_pkg::CREDIT_W-1:0] rsp_credit_value,
   output logic                        rsp_last
);
   import bvh_pkg::*;

   logic                busy_ff, busy_in;
   logic [2:0]          frame_ff, frame_in;
   logic                credit_ff, credit_in;
   logic [CREDIT_W-1:0] value_ff, value_in;
   logic [2:0]          idx_ff, idx_in;

   logic fire;
   logic frame_end;

   assign fire      = rsp_valid && rsp_ready;
   assign frame_end = !credit_ff && (idx_ff == frame_last_idx(frame_ff));

   assign rsp_valid        = busy_ff;
   assign rsp_result_kind  = credit_ff ? KIND_CREDIT : KIND_TX;
   assign rsp_tx_byte      = credit_ff ? '0 : frame_byte(frame_ff, idx_ff);
   assign rsp_credit_value = credit_ff ? value_ff : '0;
   assign rsp_last         = frame_end;

   // next job loads as the last beat of the current one leaves
   assign job_pop = !job_empty && (!busy_ff || (fire && frame_end));

   always_comb begin
      busy_in   = busy_ff;
      frame_in  = frame_ff;
      credit_in = credit_ff;
      value_in  = value_ff;
      idx_in    = idx_ff;
      if (job_pop) begin
         busy_in   = 1'b1;
         frame_in  = job_data.frame;
         credit_in = job_data.credit;
         value_in  = job_data.value;
         idx_in    = '0;
      end else if (fire) begin
         if (credit_ff) begin
            credit_in = 1'b0;
         end else if (frame_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         credit_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         credit_ff <= credit_in;
      end
   end

endmodule

// ===== hw/rtl/bill_validator_host_protocol_unit.sv =====
// ----------------------------------------------------------------------------
// bill_validator_host_protocol_unit
// Host side of a bill validator serial link: deframes received messages,
// answers with fixed command frames and reports credited bills.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_type, req_rx_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_result_kind, rsp_tx_byte,
//                                            rsp_credit_value, rsp_last
//   csr      in         csr_we               csr_index, csr_wdata
//
// a request is taken whenever the job queue has room; the front keeps taking
// requests while the back is still sending earlier results. with the back idle,
// a job is written into the queue, then loaded into the back's registers,
// before its first beat is valid; then the back sends one beat per cycle
// while rsp_ready is high: 5 or 6 frame beats per job, plus one credit beat
// on a stacked bill of nonzero value, with no gap between jobs; the queue drain
// sets the sustained rate. synchronous reset clears the receive state, the
// queue and the sender and loads the register defaults. a stalled rsp backs
// up the queue and drops req_ready once the queue is full.
// ----------------------------------------------------------------------------
module bill_validator_host_protocol_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [bvh_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_result_kind,
   output logic [bvh_pkg::BYTE_W-1:0]      rsp_tx_byte,
   output logic [bvh_pkg::CREDIT_W-1:0]    rsp_credit_value,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [bvh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bvh_pkg::CREDIT_W-1:0]    csr_wdata
);
   import bvh_pkg::*;

   logic            enable_ff;
   bill_values_type bill_values_ff;

   logic    job_full;
   logic    job_push;
   job_type push_data;
   logic    job_empty;
   logic    job_pop;
   job_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b1;
         bill_values_ff[0] <= CREDIT_W'(1000);
         bill_values_ff[1] <= CREDIT_W'(2000);
         bill_values_ff[2] <= CREDIT_W'(5000);
         bill_values_ff[3] <= CREDIT_W'(10000);
         bill_values_ff[4] <= CREDIT_W'(20000);
         bill_values_ff[5] <= CREDIT_W'(50000);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff         <= csr_wdata[0];
            CSR_BILL_0: bill_values_ff[0] <= csr_wdata;
            CSR_BILL_1: bill_values_ff[1] <= csr_wdata;
            CSR_BILL_2: bill_values_ff[2] <= csr_wdata;
            CSR_BILL_3: bill_values_ff[3] <= csr_wdata;
            CSR_BILL_4: bill_values_ff[4] <= csr_wdata;
            CSR_BILL_5: bill_values_ff[5] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bvh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_rx_byte     (req_rx_byte),
      .enable_acceptor (enable_ff),
      .bill_values     (bill_values_ff),
      .job_full        (job_full),
      .job_push        (job_push),
      .job_data        (push_data)
   );

   bvh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (pop_data)
   );

   bvh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (job_empty),
      .job_data         (pop_data),
      .job_pop          (job_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_credit_value (rsp_credit_value),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== dv/bill_validator_host_protocol_unit_test.sv =====
// ----------------------------------------------------------------------------
// bill_validator_host_protocol_unit_test
// Drives received bytes and poll ticks into the host protocol unit and checks
// every reply beat against a local host model. The run covers a short scripted
// message sequence, then random framed traffic under four register settings.
// Both handshakes stall at random, and the reply side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module bill_validator_host_protocol_unit_test;
   import bvh_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned SETTLE_CYCLES  = 64;
   localparam int unsigned LONG_HOLD      = 150;
   localparam int unsigned ITEMS_PER_PASS = 10;
   localparam int unsigned MAX_CREDIT     = 1000000;
   localparam int unsigned ENABLE_PAD_W   = CREDIT_W - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef enum logic [1:0] {HUNT_SYNC, TAKE_LEN, TAKE_BODY} link_phase_type;
   typedef enum logic [1:0] {FROM_MODEL, NO_ANSWER, FIXED_FRAME} answer_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   tx;
      logic [CREDIT_W-1:0] credit;
      logic                last;
   } beat_type;

   typedef struct packed {
      answer_type how;
      logic [2:0] frame;
   } plan_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data;
      answer_type        how;
      logic [2:0]        frame;
   } stim_row_type;

   // indexed by the frame codes of the package
   localparam logic [BYTE_W-1:0] FRAME_BYTES [7][6] = '{
      '{8'hFC, 8'h05, 8'h11, 8'h27, 8'h56, 8'h00},
      '{8'hFC, 8'h05, 8'h50, 8'hAA, 8'h05, 8'h00},
      '{8'hFC, 8'h05, 8'h40, 8'h2B, 8'h15, 8'h00},
      '{8'hFC, 8'h05, 8'h41, 8'hA2, 8'h04, 8'h00},
      '{8'hFC, 8'h05, 8'h43, 8'hB0, 8'h27, 8'h00},
      '{8'hFC, 8'h06, 8'hC3, 8'h00, 8'h04, 8'hD6},
      '{8'hFC, 8'h06, 8'hC3, 8'h01, 8'h8D, 8'hC7}
   };

   localparam stim_row_type SCRIPT [24] = '{
      '{REQ_POLL, 8'hFF,            FIXED_FRAME, FRM_STATUS},
      '{REQ_BYTE, 8'h00,            NO_ANSWER,   FRM_STATUS},
      '{REQ_BYTE, SYNC_BYTE,        NO_ANSWER,   FRM_STATUS},
      '{REQ_BYTE, 8'h04,            FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, ST_POWERUP,       FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h00,            FIXED_FRAME, FRM_RESET},
      '{REQ_BYTE, SYNC_BYTE,        FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h05,            FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, ST_ESCROW,        FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, BILL_CODE_LAST,   FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h00,            FIXED_FRAME, FRM_STACK},
      // stacked on the top code: held bill has no value, so no credit beat
      '{REQ_BYTE, SYNC_BYTE,        FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h04,            FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, ST_STACKED,       FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h00,            FIXED_FRAME, FRM_STATUS},
      // escrow just below the first bill code gets returned
      '{REQ_BYTE, SYNC_BYTE,        FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h05,            FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, ST_ESCROW,        FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h60,            FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'hFF,            FIXED_FRAME, FRM_RETURN},
      // one-byte body with a poll tick in the middle
      '{REQ_BYTE, SYNC_BYTE,        FROM_MODEL,  FRM_STATUS},
      '{REQ_BYTE, 8'h03,            FROM_MODEL,  FRM_STATUS},
      '{REQ_POLL, 8'h00,            FIXED_FRAME, FRM_STATUS},
      '{REQ_BYTE, ST_DISABLED,      FIXED_FRAME, FRM_ENABLE}
   };

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic                 req_type    = REQ_BYTE;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic                 rsp_result_kind;
   logic [BYTE_W-1:0]    rsp_tx_byte;
   logic [CREDIT_W-1:0]  rsp_credit_value;
   logic                 rsp_last;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_ENABLE;
   logic [CREDIT_W-1:0]  csr_wdata   = '0;

   // host model state
   logic                cfg_enable;
   logic [CREDIT_W-1:0] cfg_bill [NUM_BILL];
   link_phase_type      link_phase;
   logic [BYTE_W-1:0]   remaining;
   logic [1:0]          body_idx;
   logic [BYTE_W-1:0]   got_status;
   logic [BYTE_W-1:0]   got_arg;
   logic                escrow_held;
   logic [2:0]          held_bill;
   logic                held_valid;

   beat_type awaited_replies[$];
   beat_type reply_now[$];
   plan_type offered_answer[$];

   int errors        = 0;
   int sent_items    = 0;
   int accepted      = 0;
   int poll_count    = 0;
   int checked       = 0;
   int credit_count  = 0;
   int settings_used = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   bit hold_rsp_long = 1'b0;
   int watchdog;
   int hold_left;

   bill_validator_host_protocol_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_credit_value (rsp_credit_value),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic void push_frame(input logic [2:0] frm);
      int n;
      n = (frm == FRM_ENABLE || frm == FRM_DISABLE) ? 6 : 5;
      for (int i = 0; i < n; i++) begin
         reply_now.push_back('{KIND_TX, FRAME_BYTES[frm][i], '0, 1'b0});
      end
   endfunction

   // advances the host model by one item and leaves its reply in reply_now
   function automatic void compute_host_reply(input logic kind, input logic [BYTE_W-1:0] data);
      logic                answered;
      logic [CREDIT_W-1:0] value;
      reply_now.delete();
      if (kind == REQ_POLL) begin
         push_frame(FRM_STATUS);
      end else if (link_phase == HUNT_SYNC) begin
         if (data == SYNC_BYTE) begin
            link_phase = TAKE_LEN;
         end
      end else if (link_phase == TAKE_LEN) begin
         remaining  = data - LEN_OFFSET;
         body_idx   = 2'd0;
         link_phase = TAKE_BODY;
      end else begin
         if (body_idx == 2'd0) begin
            got_status = data;
            body_idx   = 2'd1;
         end else if (body_idx == 2'd1) begin
            got_arg  = data;
            body_idx = 2'd2;
         end
         remaining = remaining - 8'd1;
         if (remaining == 8'd0) begin
            link_phase = HUNT_SYNC;
            answered   = 1'b1;
            case (got_status)
               ST_IDLING: begin
                  if (!cfg_enable) push_frame(FRM_DISABLE);
                  else answered = 1'b0;
               end
               ST_ESCROW: begin
                  if (got_arg >= BILL_CODE_FIRST && got_arg <= BILL_CODE_LAST) begin
                     held_bill   = 3'(got_arg - BILL_CODE_FIRST);
                     held_valid  = 1'b1;
                     escrow_held = 1'b1;
                     push_frame(FRM_STACK);
                  end else begin
                     escrow_held = 1'b0;
                     push_frame(FRM_RETURN);
                  end
               end
               ST_VEND_VALID: begin
                  if (escrow_held) push_frame(FRM_ACK);
                  else answered = 1'b0;
               end
               ST_STACKED: begin
                  answered = 1'b0;
                  if (escrow_held) begin
                     value = '0;
                     if (held_valid && held_bill < NUM_BILL) value = cfg_bill[held_bill];
                     held_valid  = 1'b0;
                     held_bill   = '0;
                     escrow_held = 1'b0;
                     if (value != '0) begin
                        reply_now.push_back('{KIND_CREDIT, 8'h00, value, 1'b0});
                     end
                  end
               end
               ST_DISABLED: begin
                  if (cfg_enable) push_frame(FRM_ENABLE);
                  else answered = 1'b0;
               end
               ST_POWERUP, ST_POWERUP_ACC, ST_POWERUP_STACK: begin
                  push_frame(FRM_RESET);
               end
               default: answered = 1'b0;
            endcase
            if (!answered) push_frame(FRM_STATUS);
         end
      end
   endfunction

   // model update, prediction and reply check, all on pre-edge values
   always @(posedge clock) begin
      plan_type plan;
      beat_type tail;
      beat_type got;
      beat_type want;
      if (reset) begin
         cfg_enable  = 1'b1;
         cfg_bill[0] = 20'd1000;
         cfg_bill[1] = 20'd2000;
         cfg_bill[2] = 20'd5000;
         cfg_bill[3] = 20'd10000;
         cfg_bill[4] = 20'd20000;
         cfg_bill[5] = 20'd50000;
         link_phase  = HUNT_SYNC;
         remaining   = '0;
         body_idx    = '0;
         got_status  = '0;
         got_arg     = '0;
         escrow_held = 1'b0;
         held_bill   = '0;
         held_valid  = 1'b0;
         awaited_replies.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ENABLE) begin
               cfg_enable = csr_wdata[0];
            end else if (csr_index >= CSR_BILL_0 && csr_index <= CSR_BILL_5) begin
               cfg_bill[csr_index - CSR_BILL_0] = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            plan = offered_answer.pop_front();
            compute_host_reply(req_type, req_rx_byte);
            if (plan.how == NO_ANSWER) begin
               reply_now.delete();
            end else if (plan.how == FIXED_FRAME) begin
               reply_now.delete();
               push_frame(plan.frame);
            end
            if (reply_now.size() != 0) begin
               tail      = reply_now.pop_back();
               tail.last = 1'b1;
               reply_now.push_back(tail);
            end
            while (reply_now.size() != 0) awaited_replies.push_back(reply_now.pop_front());
            accepted++;
            if (req_type == REQ_POLL) poll_count++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result_kind, rsp_tx_byte, rsp_credit_value, rsp_last};
            if (awaited_replies.size() == 0) begin
               note_error($sformatf("unexpected beat kind %0d tx %02h credit %0d last %0d",
                                    got.kind, got.tx, got.credit, got.last));
            end else begin
               want = awaited_replies.pop_front();
               if (got.kind !== want.kind || got.tx !== want.tx ||
                   got.credit !== want.credit || got.last !== want.last) begin
                  note_error($sformatf({"beat %0d: expected kind %0d tx %02h credit %0d ",
                                        "last %0d, got kind %0d tx %02h credit %0d last %0d"},
                                       checked, want.kind, want.tx, want.credit, want.last,
                                       got.kind, got.tx, got.credit, got.last));
               end
               if (want.kind == KIND_CREDIT) credit_count++;
            end
            checked++;
         end
      end
   end

   // reply side: short random stalls, and one long hold-off on request
   initial begin
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) @(posedge clock);
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data,
                            input answer_type how = FROM_MODEL,
                            input logic [2:0] frame = FRM_STATUS);
      offered_answer.push_back('{how, frame});
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_rx_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // sync, length, then the body; cut stops the body early
   task automatic send_message(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] status,
                               input logic [BYTE_W-1:0] arg, input int cut);
      logic [BYTE_W-1:0] left;
      int body_n;
      left   = len - LEN_OFFSET;
      body_n = (left == 8'd0) ? 256 : int'(left);
      if (cut < body_n) body_n = cut;
      send_item(REQ_BYTE, SYNC_BYTE);
      send_item(REQ_BYTE, len);
      for (int i = 0; i < body_n; i++) begin
         if ($urandom_range(0, 29) == 0) send_item(REQ_POLL, 8'($urandom));
         send_item(REQ_BYTE, (i == 0) ? status : (i == 1) ? arg : 8'($urandom));
      end
   endtask

   function automatic logic [BYTE_W-1:0] status_pick();
      case ($urandom_range(0, 9))
         0:       return ST_IDLING;
         1:       return ST_ESCROW;
         2:       return ST_VEND_VALID;
         3:       return ST_STACKED;
         4:       return ST_DISABLED;
         5:       return ST_POWERUP;
         6:       return ST_POWERUP_ACC;
         7:       return ST_POWERUP_STACK;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic run_traffic(input int count);
      int stop_at;
      int pick;
      logic [BYTE_W-1:0] code;
      logic [BYTE_W-1:0] len;
      logic [BYTE_W-1:0] stray;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         pick = $urandom_range(0, 99);
         // codes two either side of the bill range
         code = 8'(BILL_CODE_FIRST - 8'd2 + 8'($urandom_range(0, 11)));
         len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 8)) : 8'd5;
         if (pick < 35) begin
            send_message(8'd5, ST_ESCROW, code, 256);
            if ($urandom_range(0, 4) != 0) send_message(len, ST_VEND_VALID, 8'($urandom), 256);
            send_message(8'd5, ST_STACKED, 8'($urandom), 256);
         end else if (pick < 75) begin
            send_message(len, status_pick(), code, 256);
         end else if (pick < 87) begin
            send_item(REQ_POLL, 8'($urandom));
         end else if (pick < 93) begin
            stray = 8'($urandom);
            if (stray == SYNC_BYTE) stray[0] = 1'b1;
            send_item(REQ_BYTE, stray);
         end else begin
            send_message(len, status_pick(), 8'($urandom), $urandom_range(0, 2));
         end
      end
   endtask

   task automatic wait_replies_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CREDIT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   initial begin
      for (watchdog = 0; watchdog < CYCLE_LIMIT; watchdog++) @(posedge clock);
      $display("timeout after %0d cycles with %0d beats still due",
               watchdog, awaited_replies.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults
      settings_used = 1;
      req_idle_pct  = 25;
      rsp_idle_pct  = 20;
      for (i = 0; i < $size(SCRIPT); i++) begin
         send_item(SCRIPT[i].kind, SCRIPT[i].data, SCRIPT[i].how, SCRIPT[i].frame);
      end
      run_traffic(ITEMS_PER_PASS);
      wait_replies_done();

      // acceptor disabled, bill values at the extremes
      settings_used++;
      write_reg(CSR_ENABLE, {ENABLE_PAD_W'($urandom), 1'b0});
      write_reg(CSR_BILL_0, CREDIT_W'(MAX_CREDIT));
      write_reg(CSR_BILL_1, '0);
      write_reg(CSR_BILL_2, 20'd1);
      write_reg(CSR_BILL_3, CREDIT_W'($urandom_range(0, MAX_CREDIT)));
      write_reg(CSR_BILL_4, CREDIT_W'(MAX_CREDIT - 1));
      write_reg(CSR_BILL_5, CREDIT_W'(MAX_CREDIT));
      write_reg(CSR_UNMAPPED, CREDIT_W'($urandom));
      csr_we <= 1'b0;
      req_idle_pct  = 20;
      rsp_idle_pct  = 30;
      hold_rsp_long = 1'b1;
      run_traffic(ITEMS_PER_PASS);
      // length byte 0 wraps to a 254-byte body
      send_message(8'd5, ST_ESCROW, BILL_CODE_FIRST, 256);
      send_message(8'd0, ST_STACKED, 8'h00, 256);
      wait_replies_done();

      // enabled again, random values, one bill worth nothing
      settings_used++;
      write_reg(CSR_ENABLE, {ENABLE_PAD_W'($urandom), 1'b1});
      for (i = 0; i < NUM_BILL; i++) begin
         write_reg(CSR_BILL_0 + CSR_IDX_W'(i), CREDIT_W'($urandom_range(0, MAX_CREDIT)));
      end
      write_reg(CSR_BILL_3, '0);
      csr_we <= 1'b0;
      req_idle_pct = 10;
      rsp_idle_pct = 15;
      run_traffic(ITEMS_PER_PASS);
      wait_replies_done();

      // last pass runs at full rate
      settings_used++;
      write_reg(CSR_ENABLE, CREDIT_W'($urandom));
      for (i = 0; i < NUM_BILL; i++) begin
         write_reg(CSR_BILL_0 + CSR_IDX_W'(i), CREDIT_W'($urandom_range(0, MAX_CREDIT)));
      end
      csr_we <= 1'b0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_traffic(ITEMS_PER_PASS);
      wait_replies_done();

      if (awaited_replies.size() != 0) begin
         note_error($sformatf("%0d beats never arrived", awaited_replies.size()));
      end
      $display("summary: %0d items in (%0d poll ticks), %0d reply beats checked, %0d credits",
               accepted, poll_count, checked, credit_count);
      $display("summary: %0d register settings, wrapped lengths, cut messages, long reply stall",
               settings_used);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
